// ----- design/c_literal_escaper_unit_assert.svh -----
// Assertion macros used by the C literal escaper top level.
`ifndef C_LITERAL_ESCAPER_UNIT_ASSERT_SVH
`define C_LITERAL_ESCAPER_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CLE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/cle_pkg.sv -----
// Types, constants and helper functions shared by the C literal escaper.
package cle_pkg;

	localparam logic [7:0] LINE_WIDTH_RESET = 8'd80;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	// Kind of escape produced for one raw byte.
	localparam logic [1:0] KIND_PLAIN = 2'd0;
	localparam logic [1:0] KIND_ESC   = 2'd1;
	localparam logic [1:0] KIND_HEX   = 2'd2;

	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_LOWER_T   = 8'h74;
	localparam logic [7:0] CH_LOWER_N   = 8'h6E;
	localparam logic [7:0] CH_LOWER_R   = 8'h72;
	localparam logic [7:0] CH_LOWER_X   = 8'h78;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last_of_run;
		logic       string_done;
	} out_item_t;

	// One classified byte, handed from the front end to the emitter.
	typedef struct packed {
		logic       newline;
		logic [1:0] kind;
		logic [7:0] data;
		logic       eos;
	} run_desc_t;

	function automatic logic [7:0] hex_upper(input logic [3:0] v);
		logic [7:0] wide;
		wide = {4'h0, v};
		return (v < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
	endfunction

	function automatic logic is_hex_char(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

endpackage

// ----- design/c_literal_escaper_unit.sv -----
// Top level of the C string literal escaper: front end, queue and emitter.
//
//   channel  direction  payload             one transaction carries
//   raw      in         cle_pkg::in_item_t  one raw byte and its end-of-string mark
//   esc      out        cle_pkg::out_item_t one character of the escaped text
//   cfg      in         8-bit line width    a new line width, taken at once
//
// A raw byte expands into one to five output characters (an optional line break, then one
// plain character, a two-character escape or a four-character hex escape), and the emitter
// sends one character per cycle unless the output stalls, so a longer expansion holds the output longer.
// The front end takes a new byte every cycle while the four-entry queue has room, so a stall
// on the output side only stops input once the queue fills. Reset clears the column, the hex
// flag, the queue and the output valid flag, and restores the line width to 80.
module c_literal_escaper_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               raw_valid,
	output logic               raw_ready,
	input  cle_pkg::in_item_t  raw_item,
	output logic               esc_valid,
	input  logic               esc_ready,
	output cle_pkg::out_item_t esc_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data
);

	`include "c_literal_escaper_unit_assert.svh"

	// Line width register; the port is always ready, and the user must write it
	// only while the block is idle, which the block itself does not enforce.
	logic [7:0] line_width_q;

	// Queue interface between the front end and the emitter.
	logic                          q_push;
	logic                          q_pop;
	logic                          q_empty;
	logic                          q_full;
	logic [cle_pkg::QCNT_W-1:0]    q_count;
	cle_pkg::run_desc_t            q_in;
	cle_pkg::run_desc_t            q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= cle_pkg::LINE_WIDTH_RESET;
		end else if (cfg_valid) begin
			line_width_q <= cfg_data;
		end
	end

	// The front end updates column and hex state as soon as a byte is taken,
	// since the number of characters a byte yields is known on classification.
	cle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.line_width (line_width_q),
		.raw_valid  (raw_valid),
		.raw_ready  (raw_ready),
		.raw_item   (raw_item),
		.push       (q_push),
		.push_desc  (q_in),
		.queue_full (q_full)
	);

	cle_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full),
		.count     (q_count)
	);

	// The emitter walks the queue head one character per cycle while the output is not
	// stalled, and pops it with the last character of its run.
	cle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.empty     (q_empty),
		.pop       (q_pop),
		.esc_valid (esc_valid),
		.esc_ready (esc_ready),
		.esc_item  (esc_item)
	);

	// The end of a string can only be flagged on the closing character of a run.
	`CLE_ASSERT_SAME(a_done_is_last, esc_valid && esc_item.string_done,
		esc_item.last_of_run, "string_done without last_of_run")

	// The emitter never pops an empty queue.
	`CLE_ASSERT_SAME(a_pop_not_empty, q_pop, q_count != '0, "pop from an empty queue")

	// A push without a pop leaves the queue holding at least one entry.
	`CLE_ASSERT_NEXT(a_push_fills, q_push && !q_pop, q_count != '0,
		"queue empty after a push")

	// Whenever the queue holds work, the emitter presents a character next cycle.
	`CLE_ASSERT_NEXT(a_work_shows, !q_empty, esc_valid, "queued work not emitted")

endmodule

// ----- design/cle_front.sv -----
// Front end: accepts raw bytes, tracks column and hex state, classifies each byte.
module cle_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          line_width,
	input  logic                raw_valid,
	output logic                raw_ready,
	input  cle_pkg::in_item_t   raw_item,
	output logic                push,
	output cle_pkg::run_desc_t  push_desc,
	input  logic                queue_full
);

	logic [8:0] col_q;
	logic       hex_q;

	logic       newline;
	logic [8:0] col_base;
	logic       printable;
	logic       plain;
	logic       simple;
	logic [7:0] letter;
	logic [1:0] kind;
	logic [2:0] body_len;
	logic [8:0] col_next;
	logic       hex_next;

	assign raw_ready = !queue_full;
	assign push      = raw_valid && !queue_full;

	always_comb begin
		unique case (raw_item.in_byte)
			cle_pkg::CH_TAB: begin
				simple = 1'b1;
				letter = cle_pkg::CH_LOWER_T;
			end
			cle_pkg::CH_NEWLINE: begin
				simple = 1'b1;
				letter = cle_pkg::CH_LOWER_N;
			end
			cle_pkg::CH_CR: begin
				simple = 1'b1;
				letter = cle_pkg::CH_LOWER_R;
			end
			cle_pkg::CH_QUOTE: begin
				simple = 1'b1;
				letter = cle_pkg::CH_QUOTE;
			end
			default: begin
				simple = 1'b0;
				letter = raw_item.in_byte;
			end
		endcase
	end

	always_comb begin
		newline   = (col_q >= {1'b0, line_width});
		col_base  = newline ? 9'd0 : col_q;
		printable = (raw_item.in_byte >= 8'h20) && (raw_item.in_byte <= 8'h7E) &&
			(raw_item.in_byte != cle_pkg::CH_QUOTE);
		plain     = printable && !(hex_q && cle_pkg::is_hex_char(raw_item.in_byte));

		if (plain) begin
			kind     = cle_pkg::KIND_PLAIN;
			body_len = 3'd1;
			hex_next = 1'b0;
		end else if (simple) begin
			kind     = cle_pkg::KIND_ESC;
			body_len = 3'd2;
			hex_next = hex_q;
		end else begin
			kind     = cle_pkg::KIND_HEX;
			body_len = 3'd4;
			hex_next = 1'b1;
		end
		col_next = col_base + {6'd0, body_len};

		push_desc.newline = newline;
		push_desc.kind    = kind;
		push_desc.data    = (kind == cle_pkg::KIND_ESC) ? letter : raw_item.in_byte;
		push_desc.eos     = raw_item.end_of_input;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= 9'd0;
			hex_q <= 1'b0;
		end else if (push) begin
			if (raw_item.end_of_input) begin
				col_q <= 9'd0;
				hex_q <= 1'b0;
			end else begin
				col_q <= col_next;
				hex_q <= hex_next;
			end
		end
	end

endmodule

// ----- design/cle_queue.sv -----
// Short FIFO of classified bytes between the front end and the emitter.
module cle_queue (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  cle_pkg::run_desc_t                 push_desc,
	input  logic                               pop,
	output cle_pkg::run_desc_t                 head,
	output logic                               empty,
	output logic                               full,
	output logic [cle_pkg::QCNT_W-1:0]         count
);

	cle_pkg::run_desc_t                mem_q [cle_pkg::QUEUE_DEPTH];
	logic [cle_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [cle_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [cle_pkg::QCNT_W-1:0]        count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == cle_pkg::QCNT_W'(cle_pkg::QUEUE_DEPTH));
	assign count = count_q;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/cle_back.sv -----
// Emitter: expands the queue head into output characters, one per cycle unless the output stalls.
module cle_back (
	input  logic                clk,
	input  logic                arst_n,
	input  cle_pkg::run_desc_t  head,
	input  logic                empty,
	output logic                pop,
	output logic                esc_valid,
	input  logic                esc_ready,
	output cle_pkg::out_item_t  esc_item
);

	logic [2:0]         step_q;
	logic               out_valid_q;
	cle_pkg::out_item_t out_q;

	logic       load;
	logic [2:0] body_len;
	logic [2:0] run_len;
	logic [2:0] pos;
	logic       last;
	logic [7:0] chr;

	assign esc_valid = out_valid_q;
	assign esc_item  = out_q;

	always_comb begin
		unique case (head.kind)
			cle_pkg::KIND_PLAIN: body_len = 3'd1;
			cle_pkg::KIND_ESC:   body_len = 3'd2;
			default:             body_len = 3'd4;
		endcase
		run_len = body_len + {2'd0, head.newline};
		pos     = step_q - {2'd0, head.newline};
		last    = (step_q == run_len - 3'd1);
		load    = !empty && (!out_valid_q || esc_ready);
		pop     = load && last;

		if (head.newline && step_q == 3'd0) begin
			chr = cle_pkg::CH_NEWLINE;
		end else if (head.kind == cle_pkg::KIND_PLAIN) begin
			chr = head.data;
		end else begin
			case (pos)
				3'd0:    chr = cle_pkg::CH_BACKSLASH;
				3'd1:    chr = (head.kind == cle_pkg::KIND_ESC) ? head.data
					: cle_pkg::CH_LOWER_X;
				3'd2:    chr = cle_pkg::hex_upper(head.data[7:4]);
				default: chr = cle_pkg::hex_upper(head.data[3:0]);
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_char    <= chr;
			out_q.last_of_run <= last;
			out_q.string_done <= last && head.eos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				step_q      <= last ? 3'd0 : step_q + 3'd1;
			end else if (esc_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
